FILE: hdl/lpg_pkg.sv
package lpg_pkg;

	// Width of one coordinate field on the ports.
	localparam int unsigned FIELD_W = 6;

	// Slave word: x_start, y_start, x_end, y_end from the lowest bit up.
	localparam int unsigned S_DATA_W = 4 * FIELD_W;

	// Master word: point_x, point_y, then zero fill to a whole byte count.
	localparam int unsigned M_DATA_W = ((2 * FIELD_W + 7) / 8) * 8;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

endpackage

FILE: hdl/lpg_div.sv
module lpg_div #(
	parameter int unsigned W = 6
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quot,
	output logic [W-1:0] rem
);

	localparam int unsigned CNT_W = $clog2(W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     dvd_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     dvs_q;
	logic [W:0]       shifted;
	logic [W:0]       trial;
	logic             fits;

	// One restoring step: bring down the next dividend bit and try a subtract.
	assign shifted = {rem_q, dvd_q[W-1]};
	assign trial   = shifted - {1'b0, dvs_q};
	assign fits    = (shifted >= {1'b0, dvs_q});

	// Step counter and control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient bits shift into the dividend register as its bits are used up.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[W-2:0], fits};
			rem_q <= fits ? trial[W-1:0] : shifted[W-1:0];
		end
	end

	assign done = done_q;
	assign quot = dvd_q;
	assign rem  = rem_q;

endmodule

FILE: hdl/line_point_generator.sv
// Line point generator: rasterizes the line between two endpoints.
//
// Slave channel: one word carries both endpoints. The block takes a word
// only while idle (s_tready high) and then works on that line alone.
// Master channel: one word per point of the line, x ascending, or y
// ascending when both x values match; m_tlast marks the final point.
//
// A sloped line first passes through the restoring divider, which works
// out the whole and fractional step of y per x, one quotient bit a cycle.
// After that the points leave at one per cycle while the receiver keeps
// m_tready high. A vertical run skips the divider.
//
// The output register lets the block accept the next line while the last
// point of the previous one still waits. When the receiver stalls, the
// point held on the master side stays put and the stepping waits with it.
// Reset returns the sequencer to idle and drops m_tvalid.
module line_point_generator #(
	parameter int unsigned COORD_BITS = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// x_start[5:0], y_start[11:6], x_end[17:12], y_end[23:18]
	input  logic [lpg_pkg::S_DATA_W-1:0] s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// point_x[5:0], point_y[11:6], zero fill[15:12]
	output logic [lpg_pkg::M_DATA_W-1:0] m_tdata,
	output logic                         m_tlast
);

	import lpg_pkg::*;

	localparam int unsigned C = COORD_BITS;

	state_t state_q;

	logic [C-1:0] xs, ys, xe, ye;
	logic [C-1:0] xa, ya, xb, yb;
	logic [C-1:0] ylo, yhi, dx, dy_mag;
	logic         swap, vert, dy_neg, in_acc;

	logic [C-1:0] x_q, base_q, acc_q, r_q, q0_q, r0_q, dx_q, cnt_q;
	logic         neg_q, xinc_q;

	logic         div_done;
	logic [C-1:0] div_quot, div_rem;

	logic [C-1:0] y_cur;
	logic [C:0]   r_sum;
	logic         carry;
	logic [C-1:0] r_next, acc_next;
	logic         step;

	logic [FIELD_W-1:0] px_q, py_q;
	logic               pl_q, mvalid_q;

	// Endpoint decode: keep the low COORD_BITS of each field.
	assign xs = s_tdata[C-1:0];
	assign ys = s_tdata[FIELD_W+C-1:FIELD_W];
	assign xe = s_tdata[2*FIELD_W+C-1:2*FIELD_W];
	assign ye = s_tdata[3*FIELD_W+C-1:3*FIELD_W];

	// Order the endpoints so x ascends, and take the slope apart into sign
	// and magnitude.
	always_comb begin
		vert   = (xs == xe);
		swap   = (xe < xs);
		xa     = swap ? xe : xs;
		ya     = swap ? ye : ys;
		xb     = swap ? xs : xe;
		yb     = swap ? ys : ye;
		ylo    = (ye < ys) ? ye : ys;
		yhi    = (ye < ys) ? ys : ye;
		dx     = xb - xa;
		dy_neg = (yb < ya);
		dy_mag = dy_neg ? (ya - yb) : (yb - ya);
	end

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	lpg_div #(
		.W(C)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_acc && !vert),
		.dividend(dy_mag),
		.divisor (dx),
		.done    (div_done),
		.quot    (div_quot),
		.rem     (div_rem)
	);

	// Point stepping: y offset is kept as quotient plus remainder over dx.
	always_comb begin
		y_cur    = neg_q ? (base_q - acc_q) : (base_q + acc_q);
		r_sum    = {1'b0, r_q} + {1'b0, r0_q};
		carry    = (r_sum >= {1'b0, dx_q});
		r_next   = carry ? C'(r_sum - {1'b0, dx_q}) : r_sum[C-1:0];
		acc_next = acc_q + q0_q + C'(carry);
	end

	assign step = (state_q == ST_EMIT) && (!mvalid_q || m_tready);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= vert ? ST_EMIT : ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (step && (cnt_q == '0)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Line setup and per-point stepping registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q    <= vert ? xs : xa;
			base_q <= vert ? ylo : ya;
			neg_q  <= vert ? 1'b0 : dy_neg;
			cnt_q  <= vert ? (yhi - ylo) : dx;
			dx_q   <= vert ? C'(1) : dx;
			xinc_q <= !vert;
			acc_q  <= '0;
			r_q    <= '0;
			q0_q   <= C'(1);
			r0_q   <= '0;
		end else if (div_done) begin
			q0_q <= div_quot;
			r0_q <= div_rem;
		end else if (step) begin
			x_q   <= x_q + C'(xinc_q);
			acc_q <= acc_next;
			r_q   <= r_next;
			cnt_q <= cnt_q - C'(1);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_q <= 1'b0;
		end else if (step) begin
			mvalid_q <= 1'b1;
		end else if (m_tready) begin
			mvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			px_q <= FIELD_W'(x_q);
			py_q <= FIELD_W'(y_cur);
			pl_q <= (cnt_q == '0);
		end
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata  = {{(M_DATA_W - 2 * FIELD_W){1'b0}}, py_q, px_q};
	assign m_tlast  = pl_q;

	// A taken line keeps the slave side closed on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("slave side still open after a line was taken");

	// The divider only finishes while the sequencer waits for it.
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	// Stepping always compares the remainder against a nonzero divisor.
	a_dx_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (dx_q != '0))
		else $error("zero step divisor while emitting points");

	// The final point of a line closes the sequencer on the next cycle.
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && (cnt_q == '0)) |=> (state_q == ST_IDLE) && m_tvalid && m_tlast)
		else $error("final point did not end the line");

endmodule

FILE: tb/sv/line_point_checker.sv
// Watches both channels of the line point generator. Every accepted line
// is expanded into the points it should produce, and every accepted point
// word is checked against the oldest point still outstanding.
module line_point_checker #(
	parameter int unsigned COORD_BITS = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	// x_start, y_start, x_end, y_end from the lowest bit up
	input  logic [lpg_pkg::S_DATA_W-1:0] s_tdata,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	// point_x, point_y, zero fill from the lowest bit up
	input  logic [lpg_pkg::M_DATA_W-1:0] m_tdata,
	input  logic                         m_tlast,
	output int                           mismatches,
	output int                           outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned W = lpg_pkg::FIELD_W;
	localparam int TILE_MASK = (1 << COORD_BITS) - 1;

	typedef struct packed {
		logic [W-1:0] x;
		logic [W-1:0] y;
		logic         last;
	} point_t;

	point_t line_points[$];

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	// Expands one line into its points, in the order the block emits them.
	task automatic plot_line(input logic [lpg_pkg::S_DATA_W-1:0] word);
		int xa, ya, xb, yb, swap, run, rise, i, yi;
		point_t pt;
		xa = word[0 * W +: W] & TILE_MASK;
		ya = word[1 * W +: W] & TILE_MASK;
		xb = word[2 * W +: W] & TILE_MASK;
		yb = word[3 * W +: W] & TILE_MASK;
		if (xa == xb) begin
			// Vertical run, always walked with y ascending.
			if (yb < ya) begin
				swap = ya;
				ya = yb;
				yb = swap;
			end
			for (i = ya; i <= yb; i++) begin
				pt.x = xa[W-1:0];
				pt.y = i[W-1:0];
				pt.last = (i == yb);
				line_points.push_back(pt);
			end
		end else begin
			// Sloped line, endpoints ordered so x ascends.
			if (xb < xa) begin
				swap = xa;
				xa = xb;
				xb = swap;
				swap = ya;
				ya = yb;
				yb = swap;
			end
			run = xb - xa;
			rise = yb - ya;
			for (i = xa; i <= xb; i++) begin
				// Signed integer division truncates toward zero.
				yi = ya + ((i - xa) * rise) / run;
				pt.x = i[W-1:0];
				pt.y = yi[W-1:0];
				pt.last = (i == xb);
				line_points.push_back(pt);
			end
		end
	endtask

	// Points are checked before the new line is queued, so a point seen at
	// the same edge as a line never matches that line.
	always @(posedge clk) begin : watch
		point_t seen, want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				seen.x = m_tdata[0 +: W];
				seen.y = m_tdata[W +: W];
				seen.last = m_tlast;
				if (line_points.size() == 0) begin
					$display("%0t: unexpected point x=%0d y=%0d last=%0b", $time,
						seen.x, seen.y, seen.last);
					mismatches <= mismatches + 1;
				end else begin
					want = line_points.pop_front();
					if (seen.x !== want.x || seen.y !== want.y || seen.last !== want.last) begin
						$display("%0t: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
							$time, want.x, want.y, want.last, seen.x, seen.y, seen.last);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (s_tvalid && s_tready)
				plot_line(s_tdata);
			outstanding <= line_points.size();
		end
	end

endmodule

FILE: tb/sv/tb_line_point_generator.sv
module tb_line_point_generator;
	timeunit 1ns;
	timeprecision 1ps;
	import lpg_pkg::*;

	localparam int unsigned TILE_BITS = 6;
	localparam int TOP_COORD = (1 << FIELD_W) - 1;
	localparam int unsigned RANDOM_LINES = 480;
	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned TAIL_CYCLES = 80;
	localparam int unsigned HOLD_START = 3000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned CALM_FROM = 6000;
	localparam int unsigned CALM_TO = 9000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tlast;
	int unsigned         cycle = 0;
	int unsigned         quiet = 0;
	int                  mismatches;
	int                  outstanding;
	logic                calm;

	// Neither side idles during this window.
	assign calm = (cycle >= CALM_FROM) && (cycle < CALM_TO);

	always #1 clk = ~clk;

	line_point_generator #(
		.COORD_BITS(TILE_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	line_point_checker #(
		.COORD_BITS(TILE_BITS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	function automatic logic [S_DATA_W-1:0] pack_line(int xa, int ya, int xb, int yb);
		return {yb[FIELD_W-1:0], xb[FIELD_W-1:0], ya[FIELD_W-1:0], xa[FIELD_W-1:0]};
	endfunction

	// Mostly short or degenerate lines, the rest spread over the whole tile.
	function automatic logic [S_DATA_W-1:0] random_line();
		int xa, ya, xb, yb, pick;
		xa = $urandom_range(TOP_COORD);
		ya = $urandom_range(TOP_COORD);
		xb = $urandom_range(TOP_COORD);
		yb = $urandom_range(TOP_COORD);
		pick = $urandom_range(99);
		if (pick < 10) begin
			xb = xa;
			yb = ya;
		end else if (pick < 25) begin
			xb = xa;
		end else if (pick < 55) begin
			xb = xa + int'($urandom_range(8)) - 4;
			if (xb < 0)
				xb = 0;
			if (xb > TOP_COORD)
				xb = TOP_COORD;
		end
		return pack_line(xa, ya, xb, yb);
	endfunction

	// Offers one line word, with random idle cycles ahead of it, and
	// returns at the edge where the block takes it.
	task automatic send_line(input logic [S_DATA_W-1:0] word);
		while (!calm && $urandom_range(99) < 33) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		do @(posedge clk); while (!s_tready);
	endtask

	// Cycle count and a watchdog on cycles without any accepted word.
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("tb_line_point_generator: errors");
			$finish;
		end
	end

	// Receiver: random back pressure, one long hold so the block fills up.
	initial begin : sink
		forever begin
			@(posedge clk);
			if (cycle == HOLD_START) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= calm || ($urandom_range(99) >= 33);
		end
	end

	initial begin : source
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Single points, vertical runs both ways, flat and diagonal lines,
		// reversed endpoints, steep lines with gaps and alternating bits.
		send_line(pack_line(0, 0, 0, 0));
		send_line(pack_line(63, 63, 63, 63));
		send_line(pack_line(7, 0, 7, 63));
		send_line(pack_line(7, 63, 7, 0));
		send_line(pack_line(0, 21, 63, 21));
		send_line(pack_line(0, 0, 63, 63));
		send_line(pack_line(63, 0, 0, 63));
		send_line(pack_line(0, 0, 1, 63));
		send_line(pack_line(1, 63, 0, 0));
		send_line(pack_line(0, 63, 63, 0));
		send_line(pack_line(42, 21, 21, 42));
		send_line(pack_line(21, 42, 42, 21));
		send_line(pack_line(62, 5, 63, 60));
		send_line(pack_line(10, 10, 13, 11));
		send_line(pack_line(63, 0, 62, 0));
		send_line(pack_line(0, 63, 5, 62));
		send_line(pack_line(42, 42, 42, 42));

		for (int n = 0; n < RANDOM_LINES; n++)
			send_line(random_line());
		s_tvalid <= 1'b0;

		// Drain, then give the block time to show any stray word. The
		// outstanding count is registered, so it lags the last line taken.
		do @(posedge clk); while (outstanding != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("tb_line_point_generator: clean");
		else
			$display("tb_line_point_generator: errors");
		$finish;
	end

endmodule
